// ===== hw/rtl/isfc_pkg.sv =====
// shared types and constants for the input-side fir convolver
package isfc_pkg;

  localparam int SMP_W   = 16;
  localparam int PROD_W  = 2 * SMP_W;
  localparam int SUM_W   = 38;
  localparam int FRAC_W  = 15;
  localparam int Q_W     = SUM_W - FRAC_W;
  localparam int NT_W    = 7;
  localparam int IDX_W   = 6;
  localparam int IN_D_W  = 40;

  localparam logic REQ_TAP    = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7fff;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAC   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_RD    = 5'b01000,
    ST_LD    = 5'b10000
  } state_t;

endpackage

// ===== hw/rtl/isfc_ram.sv =====
// generic single-port-write ram with registered read
module isfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/input_side_fir_convolver_unit.sv =====
// input-side fir convolver: tap and partial sum memories with a shared mac sequencer
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata tap_index,tap_value,sample_value; tuser req_type;
//          |     |                    | tlast final_sample
//  out_    | out | out_tvalid/tready  | tdata out_sample; tuser clipped; tlast run_end
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data num_taps
//
// a tap load is written on acceptance and the unit stays idle. a sample is multiply-accumulated
// over the taps through the partial sum memory, then each output is read and emitted (one
// output, or num_taps clamped to 1..MAX_TAPS on a final sample). reset (sync, active low)
// clears the valid bits of all partial sums at once, no clearing pass. a stalled output holds
// the emit sequence; the last output of a request waits in the output register while the next request is taken.
module input_side_fir_convolver_unit #(
  parameter int MAX_TAPS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [isfc_pkg::IN_D_W-1:0]   in_tdata,  // tap_index, tap_value, sample_value, pad
  input  logic                          in_tuser,  // req_type
  input  logic                          in_tlast,  // final_sample
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [isfc_pkg::SMP_W-1:0]    out_tdata, // out_sample
  output logic                          out_tuser, // clipped
  output logic                          out_tlast, // run_end
  input  logic                          cfg_wr_en,
  input  logic [isfc_pkg::NT_W-1:0]     cfg_wr_data
);
  import isfc_pkg::*;

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TW = $clog2(MAX_TAPS + 1) + 1;

  state_t state_r, state_nxt;

  logic [NT_W-1:0]          num_taps_r;
  logic [TW-1:0]            taps;
  logic [AW-1:0]            head_r, head_nxt, p_r, p1_r, p2_r;
  logic [TW-1:0]            m_r, e_r;
  logic                     s1_r, s2_r;
  logic signed [SMP_W-1:0]  x_r;
  logic                     fin_r;
  logic [MAX_TAPS-1:0]      vld_r;
  logic                     vld_q;
  logic signed [SMP_W-1:0]  tap_rd;
  logic [SUM_W-1:0]         ps_rd;
  logic signed [SUM_W-1:0]  ps_eff;
  logic signed [SUM_W-1:0]  ps2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  sum_wr;
  logic [AW-1:0]            rd_addr;
  logic                     tap_we;
  logic [IDX_W-1:0]         in_idx;
  logic signed [Q_W-1:0]    q_raw, q_adj;
  logic signed [SMP_W-1:0]  q_sat;
  logic                     q_clip;
  logic                     out_free, do_load, last_emit;
  logic                     in_acc;
  logic [SMP_W-1:0]         out_data_r;
  logic                     out_valid_r, out_user_r, out_last_r;

  always_comb begin
    if (num_taps_r == '0) begin
      taps = TW'(1);
    end else if (TW'(num_taps_r) > TW'(MAX_TAPS)) begin
      taps = TW'(MAX_TAPS);
    end else begin
      taps = TW'(num_taps_r);
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_idx    = in_tdata[IDX_W-1:0];
  assign tap_we    = in_acc && (in_tuser == REQ_TAP) && ({1'b0, in_idx} < 7'(MAX_TAPS));
  assign rd_addr   = (state_r == ST_MAC) ? p_r : head_r;

  isfc_ram #(.WIDTH(SMP_W), .DEPTH(MAX_TAPS)) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (in_idx[AW-1:0]),
    .wdata (in_tdata[IDX_W+SMP_W-1:IDX_W]),
    .raddr (m_r[AW-1:0]),
    .rdata (tap_rd)
  );

  assign sum_wr = ps2_r + SUM_W'(prod_r);

  isfc_ram #(.WIDTH(SUM_W), .DEPTH(MAX_TAPS)) u_sum_ram (
    .clk   (clk),
    .we    (s2_r),
    .waddr (p2_r),
    .wdata (sum_wr),
    .raddr (rd_addr),
    .rdata (ps_rd)
  );

  assign ps_eff = vld_q ? $signed(ps_rd) : '0;

  // divide by 2^15 toward zero, then saturate
  always_comb begin
    q_raw  = ps_eff[SUM_W-1:FRAC_W];
    q_adj  = q_raw + Q_W'(ps_eff[SUM_W-1] && (|ps_eff[FRAC_W-1:0]));
    q_clip = 1'b0;
    q_sat  = q_adj[SMP_W-1:0];
    if (q_adj > Q_W'(SMP_MAX)) begin
      q_sat  = SMP_MAX;
      q_clip = 1'b1;
    end else if (q_adj < Q_W'(SMP_MIN)) begin
      q_sat  = SMP_MIN;
      q_clip = 1'b1;
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign do_load   = (state_r == ST_LD) && out_free;
  assign last_emit = !fin_r || (e_r + TW'(1) == taps);
  assign head_nxt  = (head_r == AW'(MAX_TAPS - 1)) ? '0 : head_r + AW'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == REQ_SAMPLE) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (m_r + TW'(1) == taps) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_r && !s2_r) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_LD;
      end
      ST_LD: begin
        if (do_load) begin
          state_nxt = last_emit ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      num_taps_r  <= NT_W'(1);
      head_r      <= '0;
      vld_r       <= '0;
      s1_r        <= 1'b0;
      s2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      m_r         <= '0;
      e_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        num_taps_r <= cfg_wr_data;
      end
      s1_r <= (state_r == ST_MAC);
      s2_r <= s1_r;
      if (s2_r) begin
        vld_r[p2_r] <= 1'b1;
      end
      if (in_acc) begin
        m_r <= '0;
        e_r <= '0;
      end else if (state_r == ST_MAC) begin
        m_r <= m_r + TW'(1);
      end
      if (do_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (do_load) begin
        e_r <= e_r + TW'(1);
        if (fin_r && last_emit) begin
          vld_r  <= '0;
          head_r <= '0;
        end else begin
          vld_r[head_r] <= 1'b0;
          head_r        <= head_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r   <= in_tdata[IDX_W+2*SMP_W-1:IDX_W+SMP_W];
      fin_r <= in_tlast;
      p_r   <= head_r;
    end else if (state_r == ST_MAC) begin
      p_r <= (p_r == AW'(MAX_TAPS - 1)) ? '0 : p_r + AW'(1);
    end
    vld_q  <= vld_r[rd_addr];
    p1_r   <= p_r;
    p2_r   <= p1_r;
    prod_r <= tap_rd * x_r;
    ps2_r  <= ps_eff;
    if (do_load) begin
      out_data_r <= q_sat;
      out_user_r <= q_clip;
      out_last_r <= fin_r && last_emit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
